/* hdl/ordered_list_engine_assert.svh */
// Assertion macros shared by the list engine.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OLE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define OLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hdl/ole_pkg.sv */
// Shared constants and types of the list engine.
package ole_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam logic [2:0] OP_GET       = 3'd0;
	localparam logic [2:0] OP_ADD_HEAD  = 3'd1;
	localparam logic [2:0] OP_ADD_TAIL  = 3'd2;
	localparam logic [2:0] OP_ADD_INDEX = 3'd3;
	localparam logic [2:0] OP_DEL_INDEX = 3'd4;
	localparam logic [2:0] OP_DEL_VALUE = 3'd5;
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [31:0] NOT_FOUND = 32'hFFFF_FFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the command word
		logic rd_req;    // issue a memory read at the scan pointer, or just below it for inserts
		logic wr_req;    // write the selected word at the per-operation write address
		logic step;      // advance the scan pointer
		logic commit;    // update the length and finish the result
	} ole_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} ole_stat_t;
endpackage

/* hdl/ole_datapath.sv */
// Datapath of the list engine: entry memory, pointers, length and result.
module ole_datapath #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ole_pkg::ole_cmd_t   cmd,
	output ole_pkg::ole_stat_t  stat,
	input  logic [2:0]          operation,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  value,
	output logic signed [31:0]  res_value,
	output logic                res_found,
	output logic [1:0]          res_status,
	output logic [CW-1:0]       res_length,
	output logic [CW-1:0]       res_removed
);
	import ole_pkg::*;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_q;
	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q, new_count;
	logic [CW-1:0] at_q;     // insert or delete slot
	logic [CW-1:0] rp_q;     // scan pointer; for inserts, the slot being filled
	logic [CW-1:0] wp_q;     // write pointer
	logic [CW-1:0] rem_q;
	logic          rv_q;     // read data valid for the pending word
	logic [CW-1:0] rvp_q;    // index of the word in rdata_q
	logic [1:0]    st_q;
	logic          act_q;    // command has a scan to run (not ignored or refused)
	logic          ins_q;
	logic          pos_neg, pos_big, pos_ge, pos_gt;
	logic [CW-1:0] pos_n;
	logic          is_ins;
	logic [CW-1:0] raddr;
	logic [31:0]   wdata;
	logic [CW-1:0] waddr;
	logic          we;

	// Range tests of the incoming position against the current length.
	assign pos_neg = position[31];
	assign pos_big = !pos_neg && (position[30:0] > 31'(CAPACITY));
	assign pos_n   = CW'(position);
	assign pos_ge  = pos_big || ({1'b0, pos_n} >= {1'b0, count_q});
	assign pos_gt  = pos_big || (pos_n > count_q);

	// Inserts read the entry just below the slot being filled.
	assign is_ins = op_q inside {OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_INDEX};
	assign raddr  = is_ins ? rp_q - CW'(1) : rp_q;

	// Memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr[AW-1:0]] <= wdata;
		if (cmd.rd_req)
			rdata_q <= mem[raddr[AW-1:0]];
	end

	// Per-operation write selection during the scan.
	always_comb begin
		we = 1'b0;
		waddr = wp_q;
		wdata = rdata_q;
		if (cmd.wr_req && act_q) begin
			case (op_q)
				OP_DEL_VALUE: begin
					we = rv_q && (rdata_q != val_q);
				end
				OP_DEL_INDEX: begin
					we = rv_q && (rvp_q > at_q);
					waddr = rvp_q - CW'(1);
				end
				default: begin
					// Inserts walk downward: shift or place the new word.
					if (rv_q && rvp_q >= at_q) begin
						we = 1'b1;
						waddr = rvp_q + CW'(1);
					end else begin
						we = !rv_q;
						waddr = at_q;
						wdata = val_q;
					end
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_DEL_VALUE: stat.scan_done = !rv_q && (rp_q >= count_q);
			OP_DEL_INDEX: stat.scan_done = !rv_q && (rp_q >= count_q);
			default:      stat.scan_done = !rv_q && ins_q;
		endcase
		if (!act_q)
			stat.scan_done = 1'b1;
	end

	always_comb begin
		case (op_q)
			OP_DEL_VALUE: new_count = wp_q;
			OP_DEL_INDEX: new_count = count_q - CW'(1);
			default:      new_count = count_q + CW'(1);
		endcase
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			act_q <= 1'b0;
			rv_q <= 1'b0;
			ins_q <= 1'b0;
		end else if (cmd.load) begin
			op_q <= operation;
			val_q <= value;
			rem_q <= '0;
			rv_q <= 1'b0;
			ins_q <= 1'b0;
			wp_q <= '0;
			res_value <= NOT_FOUND;
			res_found <= 1'b0;
			act_q <= 1'b0;
			st_q <= ST_DONE;
			rp_q <= '0;
			at_q <= '0;
			case (operation)
				OP_GET: begin
					if (pos_neg || pos_ge) st_q <= ST_IGNORED;
					else begin
						act_q <= 1'b1;
						rp_q <= pos_n;
					end
				end
				OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_INDEX: begin
					if (operation == OP_ADD_INDEX && !pos_neg && pos_gt)
						st_q <= ST_IGNORED;
					else if (count_q >= CW'(CAPACITY))
						st_q <= ST_FULL;
					else begin
						act_q <= 1'b1;
						if (operation == OP_ADD_TAIL)
							at_q <= count_q;
						else if (operation == OP_ADD_INDEX && !pos_neg)
							at_q <= pos_n;
						// Fill slots downward from the first free one.
						rp_q <= count_q;
					end
				end
				OP_DEL_INDEX: begin
					if (pos_neg || pos_ge) st_q <= ST_IGNORED;
					else begin
						act_q <= 1'b1;
						at_q <= pos_n;
						rp_q <= pos_n;
					end
				end
				OP_DEL_VALUE: act_q <= 1'b1;
				default: st_q <= ST_IGNORED;
			endcase
		end else begin
			// When an insert reaches its slot, no word is moved and the new one is placed.
			if (cmd.rd_req) begin
				rv_q <= !(is_ins && rp_q == at_q);
				rvp_q <= raddr;
			end else if (cmd.wr_req)
				rv_q <= 1'b0;
			if (op_q == OP_GET && cmd.rd_req)
				act_q <= 1'b0;
			if (op_q == OP_GET && rv_q && cmd.wr_req) begin
				res_value <= rdata_q;
				res_found <= 1'b1;
			end
			if (cmd.step) begin
				if (op_q == OP_DEL_VALUE || op_q == OP_DEL_INDEX)
					rp_q <= rp_q + CW'(1);
				else if (rp_q == at_q)
					ins_q <= 1'b1;
				else
					rp_q <= rp_q - CW'(1);
			end
			if (cmd.wr_req && act_q && op_q == OP_DEL_VALUE && rv_q) begin
				if (rdata_q != val_q) wp_q <= wp_q + CW'(1);
				else rem_q <= rem_q + CW'(1);
			end
			if (cmd.commit) begin
				if (act_q && op_q != OP_GET) begin
					count_q <= new_count;
					if (op_q == OP_DEL_INDEX) rem_q <= CW'(1);
				end
				act_q <= 1'b0;
			end
		end
	end

	assign res_status  = st_q;
	assign res_length  = count_q;
	assign res_removed = rem_q;
endmodule

/* hdl/ole_control.sv */
// Controller of the list engine: sequences load, scan and result handoff.
module ole_control (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ole_pkg::ole_cmd_t  cmd,
	input  ole_pkg::ole_stat_t stat
);
	import ole_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_WRITE, S_COMMIT, S_OUT} state_t;
	state_t state_q;

	// Command decode per state.
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		case (state_q)
			S_READ: if (!stat.scan_done) begin
				cmd.rd_req = 1'b1;
				cmd.step = 1'b1;
			end
			S_WRITE: cmd.wr_req = 1'b1;
			S_COMMIT: cmd.commit = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= stat.scan_done ? S_COMMIT : S_WRITE;
				S_WRITE: state_q <= S_READ;
				S_COMMIT: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/ordered_list_engine.sv */
// Top level of the ordered list engine.
// The engine keeps an ordered list of up to CAPACITY signed 32-bit entries.
// A command word (operation, position, value) enters on the in_valid/in_ready
// channel; exactly one result word leaves on out_valid/out_ready.
// Operations: get, add at head, add at tail, add before a position, delete at
// a position, delete every entry equal to a value.
// One command is processed at a time. The entry memory has a single read and
// a single write port, and each entry moved takes a read state and a write state.
// A result waits in the output register until out_ready; meanwhile no new
// command is taken. Reset empties the list; entry contents are not cleared
// and an unwritten entry never reaches a result.
module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic signed [31:0] position,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] read_value,
	output logic        found,
	output logic [1:0]  status,
	output logic [6:0]  length,
	output logic [6:0]  removed_count
);
	import ole_pkg::*;
	`include "ordered_list_engine_assert.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	ole_cmd_t  cmd;
	ole_stat_t stat;
	logic [CW-1:0] len_w, rem_w;

	ole_control u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
	);

	ole_datapath #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_dp (
		.clk, .arst_n, .cmd, .stat, .operation, .position, .value,
		.res_value(read_value), .res_found(found), .res_status(status),
		.res_length(len_w), .res_removed(rem_w)
	);

	assign length        = 7'(len_w);
	assign removed_count = 7'(rem_w);

	// A found result always comes with done status.
	`OLE_ASSERT_IMPL(a_found_done, out_valid && found, status == ST_DONE)
	// No command is taken while a result is pending.
	`OLE_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
	// The reported length never exceeds the capacity.
	`OLE_ASSERT_IMPL(a_len_cap, out_valid, len_w <= CW'(CAPACITY))
endmodule

/* bench/ordered_list_engine_test.sv */
// Self-checking bench for the ordered list engine: directed table, fill to capacity, then random commands.
module ordered_list_engine_test;
	import ole_pkg::*;

	localparam int CAP = 64;
	localparam int LIMIT_CYCLES = 900000;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] pos;
		logic [31:0] val;
		bit          typed;
		logic [31:0] x_read;
		logic        x_found;
		logic [1:0]  x_status;
		logic [6:0]  x_length;
		logic [6:0]  x_removed;
	} row_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        found;
		logic [1:0]  status;
		logic [6:0]  length;
		logic [6:0]  removed_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic signed [31:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] read_value;
	logic found;
	logic [1:0] status;
	logic [6:0] length;
	logic [6:0] removed_count;

	ordered_list_engine dut (.*);

	// Shadow copy of the list contents.
	logic [31:0] shadow_list[CAP];
	int shadow_len = 0;
	outcome_t pending_outcomes[$];
	outcome_t typed_outcomes[$];
	bit typed_flags[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [31:0] pool[8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Insert a value before the given slot; refuses when full.
	function automatic logic [1:0] list_insert(int at, logic [31:0] v);
		if (shadow_len >= CAP)
			return ST_FULL;
		for (int i = shadow_len; i > at; i--)
			shadow_list[i] = shadow_list[i - 1];
		shadow_list[at] = v;
		shadow_len++;
		return ST_DONE;
	endfunction

	// Apply one command to the shadow list and return its outcome.
	function automatic outcome_t apply_command(logic [2:0] op, logic [31:0] pos_u,
		logic [31:0] v);
		outcome_t r;
		longint p;
		int w;
		p = longint'($signed(pos_u));
		r.read_value = NOT_FOUND;
		r.found = 1'b0;
		r.status = ST_DONE;
		r.removed_count = '0;
		case (op)
			OP_GET: begin
				if (p >= 0 && p < shadow_len) begin
					r.read_value = shadow_list[int'(p)];
					r.found = 1'b1;
				end else
					r.status = ST_IGNORED;
			end
			OP_ADD_HEAD: r.status = list_insert(0, v);
			OP_ADD_TAIL: r.status = list_insert(shadow_len, v);
			OP_ADD_INDEX: begin
				if (p > shadow_len)
					r.status = ST_IGNORED;
				else
					r.status = list_insert(p <= 0 ? 0 : int'(p), v);
			end
			OP_DEL_INDEX: begin
				if (p < 0 || p >= shadow_len)
					r.status = ST_IGNORED;
				else begin
					for (int i = int'(p); i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_len--;
					r.removed_count = 7'd1;
				end
			end
			OP_DEL_VALUE: begin
				w = 0;
				for (int i = 0; i < shadow_len; i++) begin
					if (shadow_list[i] == v)
						r.removed_count++;
					else
						shadow_list[w++] = shadow_list[i];
				end
				shadow_len = w;
			end
			default: r.status = ST_IGNORED;
		endcase
		r.length = 7'(shadow_len);
		return r;
	endfunction

	// Offer one word and wait until it is accepted; valid stays high afterward
	// until the next idle cycle or the end of sending.
	task automatic send_word(logic [2:0] op, logic [31:0] pos_u, logic [31:0] v,
		bit typed, outcome_t typed_out);
		outcome_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= op;
		position <= pos_u;
		value <= v;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = apply_command(op, pos_u, v);
		pending_outcomes.push_back(predicted);
		typed_flags.push_back(typed);
		typed_outcomes.push_back(typed_out);
		@(negedge clk);
	endtask

	// Draw a position that is mostly near the valid range.
	function automatic logic [31:0] pick_position();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'(-$urandom_range(3));
			2: return 32'(shadow_len + $urandom_range(2));
			default: return 32'($urandom_range(shadow_len > 0 ? shadow_len - 1 : 0));
		endcase
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		outcome_t none;
		logic [2:0] op;
		logic [31:0] v;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			op = 3'($urandom_range(5));
			if ($urandom_range(49) == 0)
				op = 3'($urandom_range(7, 6));
			// Bias toward inserts while short so the list fills and empties.
			if (shadow_len < 20 && $urandom_range(2) == 0)
				op = OP_ADD_TAIL;
			v = ($urandom_range(3) == 0) ? $urandom() : pool[$urandom_range(7)];
			send_word(op, pick_position(), v, 1'b0, none);
		end
	endtask

	// Receiver with random stalls; compares each word with the oldest prediction.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		outcome_t x;
		outcome_t t;
		bit typed;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result word with no command pending");
				errors++;
			end else begin
				x = pending_outcomes.pop_front();
				t = typed_outcomes.pop_front();
				typed = typed_flags.pop_front();
				if (typed && t != x) begin
					$error("typed row disagrees with prediction");
					errors++;
				end
				if (read_value !== x.read_value) begin
					$error("read_value expected %h actual %h", x.read_value, read_value);
					errors++;
				end
				if (found !== x.found) begin
					$error("found expected %b actual %b", x.found, found);
					errors++;
				end
				if (status !== x.status) begin
					$error("status expected %0d actual %0d", x.status, status);
					errors++;
				end
				if (length !== x.length) begin
					$error("length expected %0d actual %0d", x.length, length);
					errors++;
				end
				if (removed_count !== x.removed_count) begin
					$error("removed_count expected %0d actual %0d", x.removed_count,
						removed_count);
					errors++;
				end
			end
		end
		if (cycles > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Directed table: reset state, extremes, error codes.
	row_t directed[$];
	function automatic row_t mk(logic [2:0] op, logic [31:0] p, logic [31:0] v,
		bit typed = 0, logic [31:0] rv = NOT_FOUND, logic f = 0, logic [1:0] st = ST_DONE,
		logic [6:0] len = 0, logic [6:0] rem = 0);
		row_t r;
		r = '{op, p, v, typed, rv, f, st, len, rem};
		return r;
	endfunction

	initial begin
		outcome_t t;
		directed.push_back(mk(OP_GET, 0, 0, 1, NOT_FOUND, 0, ST_IGNORED, 0, 0));
		directed.push_back(mk(OP_DEL_INDEX, 0, 0, 1, NOT_FOUND, 0, ST_IGNORED, 0, 0));
		directed.push_back(mk(OP_DEL_VALUE, 0, 5, 1, NOT_FOUND, 0, ST_DONE, 0, 0));
		directed.push_back(mk(OP_ADD_INDEX, 1, 7, 1, NOT_FOUND, 0, ST_IGNORED, 0, 0));
		directed.push_back(mk(OP_ADD_HEAD, 0, 32'h7FFF_FFFF, 1, NOT_FOUND, 0, ST_DONE, 1, 0));
		directed.push_back(mk(OP_ADD_TAIL, 0, 32'h8000_0000, 1, NOT_FOUND, 0, ST_DONE, 2, 0));
		directed.push_back(mk(OP_GET, 0, 0, 1, 32'h7FFF_FFFF, 1, ST_DONE, 2, 0));
		directed.push_back(mk(OP_GET, 1, 0, 1, 32'h8000_0000, 1, ST_DONE, 2, 0));
		directed.push_back(mk(OP_GET, 32'h8000_0000, 0, 1, NOT_FOUND, 0, ST_IGNORED, 2, 0));
		directed.push_back(mk(OP_GET, 32'h7FFF_FFFF, 0, 1, NOT_FOUND, 0, ST_IGNORED, 2, 0));
		directed.push_back(mk(OP_ADD_INDEX, 32'h8000_0000, 32'hFFFF_FFFF));
		directed.push_back(mk(OP_ADD_INDEX, 3, 1));
		directed.push_back(mk(OP_ADD_INDEX, 4, 2));
		directed.push_back(mk(OP_ADD_INDEX, 32'h7FFF_FFFF, 3));
		directed.push_back(mk(OP_GET, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(OP_DEL_INDEX, 32'hFFFF_FFFF, 0));
		directed.push_back(mk(OP_DEL_INDEX, 2, 0));
		directed.push_back(mk(OP_ADD_TAIL, 0, 32'hFFFF_FFFF));
		directed.push_back(mk(OP_DEL_VALUE, 0, 32'hFFFF_FFFF));
		directed.push_back(mk(3'd6, 0, 0));
		directed.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (int i = 0; i < 8; i++)
			pool[i] = (i < 4) ? 32'(i) : $urandom();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) begin
			t = '{directed[i].x_read, directed[i].x_found, directed[i].x_status,
				directed[i].x_length, directed[i].x_removed};
			send_word(directed[i].op, directed[i].pos, directed[i].val, directed[i].typed, t);
		end
		// Fill to capacity, then check refusals of head and index inserts.
		while (shadow_len < CAP)
			send_word(OP_ADD_TAIL, 0, pool[$urandom_range(7)], 0, t);
		send_word(OP_ADD_HEAD, 0, 0, 0, t);
		send_word(OP_ADD_INDEX, 5, 0, 0, t);
		send_word(OP_ADD_INDEX, 65, 0, 0, t);
		send_word(OP_GET, 63, 0, 0, t);
		send_word(OP_DEL_VALUE, 0, pool[0], 0, t);
		random_phase(400, 0, 0);
		random_phase(300, 77, 0);
		random_phase(300, 0, 77);
		random_phase(250, 19, 19);
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
